// ===== rtl/ghash_pkg.sv =====
// ----------------------------------------------------------------------------
// ghash_pkg
// Shared types and codes of the GHASH accumulator: request codes, register
// indexes and block widths.
// ----------------------------------------------------------------------------
package ghash_pkg;

   localparam int BLOCK_BITS = 128;
   localparam int HALF_BITS  = 64;
   localparam int MAX_BYTES  = 16;

   typedef logic [BLOCK_BITS-1:0] block_type;
   typedef logic [HALF_BITS-1:0]  half_type;
   typedef logic [1:0]            req_code_type;
   typedef logic [4:0]            byte_cnt_type;
   typedef logic                  csr_idx_type;

   // request codes
   localparam req_code_type REQ_AAD    = 2'd0;
   localparam req_code_type REQ_TEXT   = 2'd1;
   localparam req_code_type REQ_FINISH = 2'd2;
   localparam req_code_type REQ_RSVD   = 2'd3;

   // register indexes
   localparam csr_idx_type CSR_KEY_HI = 1'b0;
   localparam csr_idx_type CSR_KEY_LO = 1'b1;

   localparam byte_cnt_type FULL_BLOCK = 5'd16;

endpackage

// ===== rtl/ghash_req_if.sv =====
// ----------------------------------------------------------------------------
// ghash_req_if
// Input item channel: block data, request code and valid byte count.
// ----------------------------------------------------------------------------
interface ghash_req_if;
   logic                    valid;
   logic                    ready;
   ghash_pkg::req_code_type req_type;
   ghash_pkg::half_type     block_hi;
   ghash_pkg::half_type     block_lo;
   ghash_pkg::byte_cnt_type byte_count;

   modport source (output valid, output req_type, output block_hi,
                   output block_lo, output byte_count, input ready);
   modport sink   (input valid, input req_type, input block_hi,
                   input block_lo, input byte_count, output ready);
endinterface

// ===== rtl/ghash_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ghash_rsp_if
// Result item channel: the 128-bit hash as two halves.
// ----------------------------------------------------------------------------
interface ghash_rsp_if;
   logic                valid;
   logic                ready;
   ghash_pkg::half_type hash_hi;
   ghash_pkg::half_type hash_lo;

   modport source (output valid, output hash_hi, output hash_lo, input ready);
   modport sink   (input valid, input hash_hi, input hash_lo, output ready);
endinterface

// ===== rtl/ghash_gfmul.sv =====
// ----------------------------------------------------------------------------
// ghash_gfmul
// Combinational GF(2^128) multiplier in GCM bit order (field bit 0 is the
// MSB of the word). Carry-less product followed by a two-fold reduction
// with x^128 = x^7 + x^2 + x + 1.
// ----------------------------------------------------------------------------
module ghash_gfmul (
   input  ghash_pkg::block_type op_a,
   input  ghash_pkg::block_type op_b,
   output ghash_pkg::block_type product
);

   ghash_pkg::block_type a_rev;
   ghash_pkg::block_type b_rev;
   ghash_pkg::block_type red;
   logic [254:0]         clmul;
   logic [126:0]         high;
   logic [134:0]         fold1;
   logic [6:0]           spill;

   // bit-reverse so that coefficient i sits at bit i
   always_comb begin
      for (int i = 0; i < 128; i++) begin
         a_rev[i] = op_a[127-i];
         b_rev[i] = op_b[127-i];
      end
   end

   always_comb begin
      clmul = '0;
      for (int i = 0; i < 128; i++) begin
         if (a_rev[i]) begin
            clmul = clmul ^ ({127'b0, b_rev} << i);
         end
      end
   end

   assign high  = clmul[254:128];
   assign fold1 = {7'b0, clmul[127:0]} ^ {8'b0, high} ^ {7'b0, high, 1'b0}
                ^ {6'b0, high, 2'b00} ^ {1'b0, high, 7'b0};
   assign spill = fold1[134:128];
   assign red   = fold1[127:0] ^ {121'b0, spill} ^ {120'b0, spill, 1'b0}
                ^ {119'b0, spill, 2'b00} ^ {114'b0, spill, 7'b0};

   always_comb begin
      for (int i = 0; i < 128; i++) begin
         product[i] = red[127-i];
      end
   end

endmodule

// ===== rtl/ghash_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// ghash_accumulator_core
// GCM GHASH accumulator with hash subkey registers, byte counters and a
// finish request that folds in the length block and returns the hash.
// ----------------------------------------------------------------------------
// Takes one item per clock while no finish item is held back. An accepted
// item is padded and registered, and in the next cycle the accumulator XOR
// block is multiplied by H and written back, so data items sustain one per
// cycle and pass the stage-1 register before the accumulator register. A
// finish item passes the stage-1 and result registers before its hash is on
// rsp; it holds the input side only while the previous hash is still waiting
// to be taken. The combinational 128x128 GF(2^128) multiplier that closes the
// accumulator feedback loop sets the rate. H must be written while idle.
module ghash_accumulator_core #(
   parameter int COUNT_BITS = 61
) (
   input  logic                       clock,
   input  logic                       reset,
   ghash_req_if.sink                  req,
   ghash_rsp_if.source                rsp,
   input  logic                       csr_write_en,
   input  ghash_pkg::csr_idx_type     csr_index,
   input  ghash_pkg::half_type        csr_wdata
);

   // key registers
   ghash_pkg::half_type key_hi_ff, key_lo_ff;

   // stage 1: registered, padded item
   logic                    s1_valid_ff, s1_valid_in;
   ghash_pkg::req_code_type s1_req_ff;
   ghash_pkg::block_type    s1_blk_ff;
   ghash_pkg::byte_cnt_type s1_cnt_ff;

   // stage 2: accumulator, counters and result register
   ghash_pkg::block_type    acc_ff, acc_in;
   logic [COUNT_BITS-1:0]   aad_cnt_ff, aad_cnt_in;
   logic [COUNT_BITS-1:0]   text_cnt_ff, text_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ghash_pkg::block_type    hash_ff;

   logic                    req_fire;
   logic                    ex_fire;
   logic                    is_fin;
   logic                    is_aad;
   logic                    is_text;
   ghash_pkg::byte_cnt_type n_sat;
   ghash_pkg::block_type    pad_mask;
   ghash_pkg::block_type    len_blk;
   ghash_pkg::block_type    mul_in;
   ghash_pkg::block_type    mul_out;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ghash_pkg::CSR_KEY_HI: key_hi_ff <= csr_wdata;
            ghash_pkg::CSR_KEY_LO: key_lo_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- input padding ----------------
   assign n_sat = (req.byte_count > ghash_pkg::FULL_BLOCK) ? ghash_pkg::FULL_BLOCK
                                                           : req.byte_count;

   always_comb begin
      for (int b = 0; b < ghash_pkg::MAX_BYTES; b++) begin
         pad_mask[127-8*b -: 8] = {8{5'(b) < n_sat}};
      end
   end

   assign req_fire  = req.valid && req.ready;
   assign req.ready = !s1_valid_ff || ex_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (ex_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req.req_type;
         s1_blk_ff <= {req.block_hi, req.block_lo} & pad_mask;
         s1_cnt_ff <= n_sat;
      end
   end

   // ---------------- hash stage ----------------
   assign is_fin  = s1_req_ff == ghash_pkg::REQ_FINISH;
   assign is_aad  = s1_req_ff == ghash_pkg::REQ_AAD;
   assign is_text = s1_req_ff == ghash_pkg::REQ_TEXT;

   // a finish waits only for a free result register
   assign ex_fire = s1_valid_ff && (!is_fin || !rsp_valid_ff || rsp.ready);

   // length block: bit counts, big-endian
   assign len_blk = {64'({aad_cnt_ff, 3'b000}), 64'({text_cnt_ff, 3'b000})};
   assign mul_in  = acc_ff ^ (is_fin ? len_blk : s1_blk_ff);

   ghash_gfmul u_gfmul (
      .op_a    (mul_in),
      .op_b    ({key_hi_ff, key_lo_ff}),
      .product (mul_out)
   );

   always_comb begin
      acc_in      = acc_ff;
      aad_cnt_in  = aad_cnt_ff;
      text_cnt_in = text_cnt_ff;
      if (ex_fire) begin
         if (is_fin) begin
            acc_in      = '0;
            aad_cnt_in  = '0;
            text_cnt_in = '0;
         end else if (is_aad) begin
            acc_in     = mul_out;
            aad_cnt_in = aad_cnt_ff + COUNT_BITS'(s1_cnt_ff);
         end else if (is_text) begin
            acc_in      = mul_out;
            text_cnt_in = text_cnt_ff + COUNT_BITS'(s1_cnt_ff);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ex_fire && is_fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         aad_cnt_ff   <= '0;
         text_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         aad_cnt_ff   <= aad_cnt_in;
         text_cnt_ff  <= text_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_fire && is_fin) begin
         hash_ff <= mul_out;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.hash_hi = hash_ff[127:64];
   assign rsp.hash_lo = hash_ff[63:0];

   // ---------------- assertions ----------------
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ex_fire && is_fin))
      else $error("result appeared without a finish item");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (ex_fire && is_fin) |=> (acc_ff == '0 && aad_cnt_ff == '0 && text_cnt_ff == '0))
      else $error("state not cleared after finish");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled without a pending result");

   a_rsvd_no_effect: assert property (@(posedge clock) disable iff (reset)
      (ex_fire && s1_req_ff == ghash_pkg::REQ_RSVD) |=>
         ($stable(acc_ff) && $stable(aad_cnt_ff) && $stable(text_cnt_ff)))
      else $error("reserved request changed state");

endmodule
